>>> rtl/core/coc_pkg.sv
// Package for the connection opening classifier.
// Verdict codes, pattern tables and state codes; no dependencies.
package coc_pkg;

   // Result codes
   typedef enum logic [2:0] {
      VERDICT_ROOT  = 3'd0,
      VERDICT_TLS   = 3'd1,
      VERDICT_HTTP  = 3'd2,
      VERDICT_SSH   = 3'd3,
      VERDICT_EMPTY = 3'd4,
      VERDICT_JUNK  = 3'd5
   } verdict_type;

   // TLS record header tracking
   typedef enum logic [1:0] {
      TLS_NONE    = 2'd0,
      TLS_TYPE_OK = 2'd1,
      TLS_MATCH   = 2'd2,
      TLS_FAIL    = 2'd3
   } tls_type;

   localparam int NUM_VERBS = 9;
   localparam int VERB_MAX  = 8;

   localparam logic [4:0] FULL_COUNT   = 5'd16;
   localparam logic [4:0] LEAD_COUNT   = 5'd12;
   localparam logic [4:0] LAST_INDEX   = 5'd15;
   localparam logic [4:0] SSH_LAST     = 5'd3;
   localparam logic [4:0] VERB_LIMIT   = 5'd8;
   localparam logic [7:0] ROOT_TAIL    = 8'h04;
   localparam logic [7:0] TLS_TYPE     = 8'h16;
   localparam logic [7:0] TLS_MAJOR    = 8'h03;

   // Method tokens with their trailing space, zero padded
   localparam logic [7:0] VERB_TEXT [NUM_VERBS][VERB_MAX] = '{
      '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},   // GET
      '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},   // POST
      '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00},   // HEAD
      '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},   // PUT
      '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h20},   // OPTIONS
      '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00},   // DELETE
      '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h20},   // CONNECT
      '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h20, 8'h00, 8'h00},   // TRACE
      '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h20, 8'h00, 8'h00}    // PATCH
   };

   localparam logic [4:0] VERB_LEN [NUM_VERBS] = '{
      5'd4, 5'd5, 5'd5, 5'd4, 5'd8, 5'd7, 5'd8, 5'd6, 5'd6
   };

   // SSH banner prefix
   localparam logic [7:0] SSH_TEXT [4] = '{8'h53, 8'h53, 8'h48, 8'h2D};

endpackage

>>> rtl/core/connection_opening_classifier_top.sv
// Connection opening classifier, top level.
// Depends on coc_pkg for verdict codes and pattern tables.
//
// Usage:
//   The req_ channel carries one opening byte per request (req_data_byte,
//   qualified by req_byte_valid) and req_start_req, which begins a new
//   connection and forgets earlier bytes before the request is applied.
//   Every request yields exactly one response on the rsp_ channel:
//   rsp_verdict (root, TLS, HTTP, SSH, empty, junk) and rsp_awaiting_bytes,
//   set while a root prefix holds and fewer than sixteen bytes are in.
//   A request accepted into the input register is classified by the
//   pattern trackers and its verdict written to the result register,
//   from which its response is taken.
//   Throughput: one request per cycle while rsp_ready is high; the
//   pattern trackers update combinationally between the two registers.
//   Reset: both pipeline stages empty, trackers in the empty-connection
//   state, as if a new connection had started.
//   Stall: when a response is valid and rsp_ready is low the result
//   register holds; an empty input register still takes one more
//   request, then req_ready drops until the result is taken.
module connection_opening_classifier_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_valid,
   input  logic       req_start_req,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_verdict,
   output logic       rsp_awaiting_bytes
);

   // Input register
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_byte_valid_ff;
   logic                 in_start_ff;

   // Tracker state
   logic [4:0]           bytes_seen_ff, bytes_seen_in;
   logic                 zero_lead_ok_ff, zero_lead_ok_in;
   logic                 fourth_word_ok_ff, fourth_word_ok_in;
   coc_pkg::tls_type     tls_progress_ff, tls_progress_in;
   logic [coc_pkg::NUM_VERBS-1:0] verb_alive_ff, verb_alive_in;
   logic                 http_hit_ff, http_hit_in;
   logic                 ssh_alive_ff, ssh_alive_in;
   logic                 ssh_hit_ff, ssh_hit_in;

   // Result register
   logic                 rsp_valid_ff;
   coc_pkg::verdict_type verdict_ff, verdict_in;
   logic                 awaiting_bytes_ff, awaiting_bytes_in;

   logic                 advance;
   logic [4:0]           idx;
   logic [7:0]           b;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   // Tracker update for the request in the input register
   always_comb begin
      if (in_start_ff) begin
         bytes_seen_in     = '0;
         zero_lead_ok_in   = 1'b1;
         fourth_word_ok_in = 1'b1;
         tls_progress_in   = coc_pkg::TLS_NONE;
         verb_alive_in     = '1;
         http_hit_in       = 1'b0;
         ssh_alive_in      = 1'b1;
         ssh_hit_in        = 1'b0;
      end else begin
         bytes_seen_in     = bytes_seen_ff;
         zero_lead_ok_in   = zero_lead_ok_ff;
         fourth_word_ok_in = fourth_word_ok_ff;
         tls_progress_in   = tls_progress_ff;
         verb_alive_in     = verb_alive_ff;
         http_hit_in       = http_hit_ff;
         ssh_alive_in      = ssh_alive_ff;
         ssh_hit_in        = ssh_hit_ff;
      end

      idx = bytes_seen_in;
      b   = in_byte_ff;

      if (in_byte_valid_ff) begin
         // zero lead and fourth word
         if (idx < coc_pkg::LEAD_COUNT && b != 8'h00)
            zero_lead_ok_in = 1'b0;
         if (idx >= coc_pkg::LEAD_COUNT && idx < coc_pkg::FULL_COUNT) begin
            if (b != ((idx == coc_pkg::LAST_INDEX) ? coc_pkg::ROOT_TAIL : 8'h00))
               fourth_word_ok_in = 1'b0;
         end

         // TLS record header
         if (idx == 5'd0)
            tls_progress_in = (b == coc_pkg::TLS_TYPE) ? coc_pkg::TLS_TYPE_OK
                                                       : coc_pkg::TLS_FAIL;
         else if (idx == 5'd1 && tls_progress_in == coc_pkg::TLS_TYPE_OK)
            tls_progress_in = (b == coc_pkg::TLS_MAJOR) ? coc_pkg::TLS_MATCH
                                                        : coc_pkg::TLS_FAIL;

         // method tokens, one independent compare per token
         if (idx < coc_pkg::VERB_LIMIT) begin
            for (int v = 0; v < coc_pkg::NUM_VERBS; v++) begin
               if (verb_alive_in[v]) begin
                  if (idx < coc_pkg::VERB_LEN[v] &&
                      b == coc_pkg::VERB_TEXT[v][idx[2:0]]) begin
                     if (idx + 5'd1 == coc_pkg::VERB_LEN[v])
                        http_hit_in = 1'b1;
                  end else begin
                     verb_alive_in[v] = 1'b0;
                  end
               end
            end
         end

         // SSH banner
         if (idx <= coc_pkg::SSH_LAST && ssh_alive_in) begin
            if (b == coc_pkg::SSH_TEXT[idx[1:0]]) begin
               if (idx == coc_pkg::SSH_LAST)
                  ssh_hit_in = 1'b1;
            end else begin
               ssh_alive_in = 1'b0;
            end
         end

         if (idx < coc_pkg::FULL_COUNT)
            bytes_seen_in = idx + 5'd1;
      end
   end

   // Verdict from the updated trackers, in priority order
   always_comb begin
      awaiting_bytes_in = 1'b0;
      priority if (bytes_seen_in == 5'd0) begin
         verdict_in = coc_pkg::VERDICT_EMPTY;
      end else if (zero_lead_ok_in) begin
         if (bytes_seen_in < coc_pkg::FULL_COUNT) begin
            verdict_in        = coc_pkg::VERDICT_ROOT;
            awaiting_bytes_in = 1'b1;
         end else begin
            verdict_in = fourth_word_ok_in ? coc_pkg::VERDICT_ROOT
                                           : coc_pkg::VERDICT_JUNK;
         end
      end else if (tls_progress_in == coc_pkg::TLS_MATCH) begin
         verdict_in = coc_pkg::VERDICT_TLS;
      end else if (http_hit_in) begin
         verdict_in = coc_pkg::VERDICT_HTTP;
      end else if (ssh_hit_in) begin
         verdict_in = coc_pkg::VERDICT_SSH;
      end else begin
         verdict_in = coc_pkg::VERDICT_JUNK;
      end
   end

   // Control and tracker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         bytes_seen_ff     <= '0;
         zero_lead_ok_ff   <= 1'b1;
         fourth_word_ok_ff <= 1'b1;
         tls_progress_ff   <= coc_pkg::TLS_NONE;
         verb_alive_ff     <= '1;
         http_hit_ff       <= 1'b0;
         ssh_alive_ff      <= 1'b1;
         ssh_hit_ff        <= 1'b0;
      end else begin
         if (req_ready)
            in_valid_ff <= req_valid;
         if (advance)
            rsp_valid_ff <= in_valid_ff;
         if (advance && in_valid_ff) begin
            bytes_seen_ff     <= bytes_seen_in;
            zero_lead_ok_ff   <= zero_lead_ok_in;
            fourth_word_ok_ff <= fourth_word_ok_in;
            tls_progress_ff   <= tls_progress_in;
            verb_alive_ff     <= verb_alive_in;
            http_hit_ff       <= http_hit_in;
            ssh_alive_ff      <= ssh_alive_in;
            ssh_hit_ff        <= ssh_hit_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff       <= req_data_byte;
         in_byte_valid_ff <= req_byte_valid;
         in_start_ff      <= req_start_req;
      end
      if (advance && in_valid_ff) begin
         verdict_ff        <= verdict_in;
         awaiting_bytes_ff <= awaiting_bytes_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_awaiting_bytes = awaiting_bytes_ff;

endmodule

>>> rtl/core/coc_checker.sv
// Port-level checker for connection_opening_classifier_top, with its bind.
// Depends on coc_pkg for verdict codes.
module coc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_verdict,
   input logic       rsp_awaiting_bytes
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict) &&
                                  $stable(rsp_awaiting_bytes))
      else $error("stalled response changed");

   // awaiting_bytes only with a root verdict
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_awaiting_bytes |-> rsp_verdict == coc_pkg::VERDICT_ROOT)
      else $error("awaiting_bytes without root verdict");

   // verdict code within the defined set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= coc_pkg::VERDICT_JUNK)
      else $error("undefined verdict code");

   // pipeline empties at reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind connection_opening_classifier_top coc_checker u_coc_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for connection_opening_classifier_top.
// Uses coc_pkg for verdict and TLS tracking codes; needs nothing but the RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASE_ITEMS  = 64;

   // Opening layout
   localparam int  OPENING_FULL  = 16;
   localparam int  ZERO_LEAD     = 12;
   localparam int  TAIL_LAST     = 15;
   localparam int  TOKEN_WINDOW  = 8;
   localparam int  BANNER_LEN    = 4;
   localparam logic [7:0] ROOT_TAIL_BYTE = 8'h04;
   localparam logic [7:0] RECORD_TYPE    = 8'h16;
   localparam logic [7:0] RECORD_MAJOR   = 8'h03;
   localparam logic [8:0] ALL_METHODS    = 9'h1FF;
   localparam int  NUM_METHODS   = 9;

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       start_req;
   } opening_request_type;

   typedef struct {
      coc_pkg::verdict_type verdict;
      logic                 awaiting_bytes;
   } opening_verdict_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_byte_valid = 1'b0;
   logic       req_start_req = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_verdict;
   logic       rsp_awaiting_bytes;

   opening_request_type pending_requests[$];
   opening_verdict_type verdict_queue[$];
   int queued_count = 0;
   int accepted_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   // Predictor copy of the pattern trackers
   logic [4:0]       seen_count;
   logic             lead_zero;
   logic             tail_word_ok;
   coc_pkg::tls_type tls_state;
   logic [8:0]       methods_live;
   logic             method_done;
   logic             banner_live;
   logic             banner_done;

   connection_opening_classifier_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_start_req      (req_start_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_awaiting_bytes (rsp_awaiting_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Method token with its trailing space
   function automatic string method_token(input int v);
      case (v)
         0: return "GET ";
         1: return "POST ";
         2: return "HEAD ";
         3: return "PUT ";
         4: return "OPTIONS ";
         5: return "DELETE ";
         6: return "CONNECT ";
         7: return "TRACE ";
         default: return "PATCH ";
      endcase
   endfunction

   function automatic void restart_tracking();
      seen_count   = 5'd0;
      lead_zero    = 1'b1;
      tail_word_ok = 1'b1;
      tls_state    = coc_pkg::TLS_NONE;
      methods_live = ALL_METHODS;
      method_done  = 1'b0;
      banner_live  = 1'b1;
      banner_done  = 1'b0;
   endfunction

   // Advance every pattern tracker by one byte
   function automatic void track_byte(input logic [7:0] b);
      int    idx;
      string tok;
      string banner;
      logic [7:0] tail_want;
      idx = int'(seen_count);
      banner = "SSH-";
      if (idx < ZERO_LEAD && b != 8'h00)
         lead_zero = 1'b0;
      if (idx >= ZERO_LEAD && idx < OPENING_FULL) begin
         tail_want = (idx == TAIL_LAST) ? ROOT_TAIL_BYTE : 8'h00;
         if (b != tail_want)
            tail_word_ok = 1'b0;
      end
      if (idx == 0)
         tls_state = (b == RECORD_TYPE) ? coc_pkg::TLS_TYPE_OK : coc_pkg::TLS_FAIL;
      else if (idx == 1 && tls_state == coc_pkg::TLS_TYPE_OK)
         tls_state = (b == RECORD_MAJOR) ? coc_pkg::TLS_MATCH : coc_pkg::TLS_FAIL;
      if (idx < TOKEN_WINDOW) begin
         for (int v = 0; v < NUM_METHODS; v++) begin
            if (methods_live[v]) begin
               tok = method_token(v);
               if (idx < tok.len() && b == tok[idx]) begin
                  if (idx + 1 == tok.len())
                     method_done = 1'b1;
               end else begin
                  methods_live[v] = 1'b0;
               end
            end
         end
      end
      if (idx < BANNER_LEN && banner_live) begin
         if (b == banner[idx]) begin
            if (idx == BANNER_LEN - 1)
               banner_done = 1'b1;
         end else begin
            banner_live = 1'b0;
         end
      end
      if (idx < OPENING_FULL)
         seen_count = seen_count + 5'd1;
   endfunction

   // Expected response for one accepted request
   function automatic void predict_verdict(input logic [7:0] b, input logic bv,
                                           input logic st,
                                           output coc_pkg::verdict_type v,
                                           output logic more);
      if (st)
         restart_tracking();
      if (bv)
         track_byte(b);
      more = 1'b0;
      if (seen_count == 5'd0) begin
         v = coc_pkg::VERDICT_EMPTY;
      end else if (lead_zero) begin
         if (int'(seen_count) < OPENING_FULL) begin
            v = coc_pkg::VERDICT_ROOT;
            more = 1'b1;
         end else begin
            v = tail_word_ok ? coc_pkg::VERDICT_ROOT : coc_pkg::VERDICT_JUNK;
         end
      end else if (tls_state == coc_pkg::TLS_MATCH) begin
         v = coc_pkg::VERDICT_TLS;
      end else if (method_done) begin
         v = coc_pkg::VERDICT_HTTP;
      end else if (banner_done) begin
         v = coc_pkg::VERDICT_SSH;
      end else begin
         v = coc_pkg::VERDICT_JUNK;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Idle rates per traffic phase: none, sender, receiver, both
   function automatic int sender_idle_pct();
      case ((accepted_count / PHASE_ITEMS) % 4)
         1: return 46;
         3: return 6;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case ((accepted_count / PHASE_ITEMS) % 4)
         2: return 46;
         3: return 6;
         default: return 0;
      endcase
   endfunction

   task automatic queue_request(input logic [7:0] b, input logic bv, input logic st);
      opening_request_type item;
      item.data_byte  = b;
      item.byte_valid = bv;
      item.start_req  = st;
      pending_requests.push_back(item);
      queued_count++;
   endtask

   // Byte with an occasional report-only request in front of it
   task automatic queue_byte(input logic [7:0] b, input logic st);
      if ($urandom_range(99) < 8)
         queue_request(8'($urandom_range(255)), 1'b0, 1'b0);
      queue_request(b, 1'b1, st);
   endtask

   task automatic queue_directed();
      // report before any connection, then empty new connection
      queue_request(8'hFF, 1'b0, 1'b0);
      queue_request(8'hFF, 1'b0, 1'b1);
      // full root handshake, one byte past the end, then a bare report
      for (int i = 0; i < OPENING_FULL; i++)
         queue_request((i == TAIL_LAST) ? ROOT_TAIL_BYTE : 8'h00, 1'b1, 1'b0);
      queue_request(8'hFF, 1'b1, 1'b0);
      queue_request(8'h5A, 1'b0, 1'b0);
      // TLS record header
      queue_request(RECORD_TYPE, 1'b1, 1'b1);
      queue_request(RECORD_MAJOR, 1'b1, 1'b0);
      // junk
      queue_request(8'hFF, 1'b1, 1'b1);
      // SSH banner
      queue_request(8'h53, 1'b1, 1'b1);
      queue_request(8'h53, 1'b1, 1'b0);
      queue_request(8'h48, 1'b1, 1'b0);
      queue_request(8'h2D, 1'b1, 1'b0);
   endtask

   // Random connections, mostly well-formed openings with random content
   task automatic queue_random(input int target);
      logic [7:0] opening[24];
      int    kind;
      int    len;
      int    v;
      int    pick;
      string tok;
      string banner;
      logic  start_with_byte;
      banner = "SSH-";
      while (queued_count < target) begin
         kind = $urandom_range(9);
         for (int i = 0; i < 24; i++)
            opening[i] = 8'($urandom_range(255));
         case (kind)
            0, 1: begin
               for (int i = 0; i < OPENING_FULL; i++)
                  opening[i] = (i == TAIL_LAST) ? ROOT_TAIL_BYTE : 8'h00;
               len = OPENING_FULL + $urandom_range(4);
            end
            2: begin
               // nonzero bytes inside the fourth word
               for (int i = 0; i < ZERO_LEAD; i++)
                  opening[i] = 8'h00;
               for (int i = ZERO_LEAD; i < TAIL_LAST; i++)
                  opening[i] = 8'($urandom_range(255, 1));
               len = $urandom_range(18, ZERO_LEAD + 1);
            end
            3: begin
               opening[0] = RECORD_TYPE;
               opening[1] = RECORD_MAJOR;
               len = $urandom_range(8, 2);
            end
            4, 5: begin
               tok = method_token($urandom_range(NUM_METHODS - 1));
               for (int i = 0; i < tok.len(); i++)
                  opening[i] = tok[i];
               len = tok.len() + $urandom_range(4);
            end
            6: begin
               for (int i = 0; i < BANNER_LEN; i++)
                  opening[i] = banner[i];
               len = $urandom_range(8, BANNER_LEN);
            end
            7: len = $urandom_range(20, 1);
            8: begin
               // bytes drawn from the pattern alphabets for near misses
               len = $urandom_range(20, 1);
               for (int i = 0; i < len; i++) begin
                  pick = $urandom_range(3);
                  if (pick == 0) begin
                     tok = method_token($urandom_range(NUM_METHODS - 1));
                     v = $urandom_range(tok.len() - 1);
                     opening[i] = tok[v];
                  end else if (pick == 1) begin
                     opening[i] = banner[$urandom_range(BANNER_LEN - 1)];
                  end else if (pick == 2) begin
                     opening[i] = 8'h00;
                  end else begin
                     case ($urandom_range(3))
                        0: opening[i] = RECORD_TYPE;
                        1: opening[i] = RECORD_MAJOR;
                        2: opening[i] = ROOT_TAIL_BYTE;
                        default: opening[i] = 8'h20;
                     endcase
                  end
               end
            end
            default: begin
               len = $urandom_range(20, 1);
               for (int i = 0; i < len; i++)
                  opening[i] = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'h00;
            end
         endcase
         if ($urandom_range(3) == 0)
            opening[$urandom_range(len - 1)] = 8'($urandom_range(255));
         if ($urandom_range(3) == 0)
            len = $urandom_range(len, 1);
         // new connection either empty first or opened by its first byte
         start_with_byte = ($urandom_range(5) != 0);
         if (!start_with_byte)
            queue_request(8'($urandom_range(255)), 1'b0, 1'b1);
         for (int i = 0; i < len; i++)
            queue_byte(opening[i], start_with_byte && i == 0);
      end
   endtask

   // Request driver
   always @(posedge clock) begin : request_driver
      opening_request_type item;
      opening_verdict_type want;
      if (reset) begin
         req_valid <= 1'b0;
         restart_tracking();
      end else begin
         if (req_valid && req_ready) begin
            predict_verdict(req_data_byte, req_byte_valid, req_start_req,
                            want.verdict, want.awaiting_bytes);
            verdict_queue.push_back(want);
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               item = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= item.data_byte;
               req_byte_valid <= item.byte_valid;
               req_start_req  <= item.start_req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct());
   end

   // Response monitor
   always @(posedge clock) begin : response_monitor
      opening_verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_verdict !== want.verdict)
               report_mismatch($sformatf("verdict %0d, expected %0d",
                                         rsp_verdict, want.verdict));
            if (rsp_awaiting_bytes !== want.awaiting_bytes)
               report_mismatch($sformatf("awaiting_bytes %0b, expected %0b",
                                         rsp_awaiting_bytes, want.awaiting_bytes));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      queue_directed();
      queue_random(queued_count + RANDOM_ITEMS);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_valid || verdict_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_queue.size() != 0)
         report_mismatch("requests left without a response");
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/core/coc_pkg.sv
rtl/core/connection_opening_classifier_top.sv
rtl/core/coc_checker.sv
tb/testbench.sv
